// ----- rtl/sfr_pkg.sv -----
// Shared constants and types for the sensor frame receiver.
`default_nettype none

package sfr_pkg;

  localparam int BufferDepth   = 64;
  localparam int FrameOverhead = 4;
  localparam int MaxLength     = BufferDepth + FrameOverhead;

  localparam int ByteW     = 8;
  localparam int ByteIdxW  = 6;
  localparam int LenFieldW = 6;
  localparam int CntW      = (BufferDepth > 1) ? $clog2(BufferDepth) : 1;
  localparam int CfgIdxW   = 1;

  localparam logic [CfgIdxW-1:0] CfgHeaderFirst  = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgHeaderSecond = 1'd1;

  localparam logic [ByteW-1:0] HeaderFirstReset  = 8'd170;
  localparam logic [ByteW-1:0] HeaderSecondReset = 8'd85;

  typedef struct packed {
    logic sum_load;
    logic sum_add;
    logic len_load;
    logic func_load;
    logic fill_clr;
    logic store_wr;
    logic emit_start;
    logic rd_en;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic rx_eq_h1;
    logic rx_eq_h2;
    logic len_bad;
    logic fill_done;
    logic sum_match;
    logic emit_last;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

// ----- rtl/sfr_ifs.sv -----
// Channel interfaces: received bytes, frame results and register writes.
`default_nettype none

interface sfr_rx_if;
  import sfr_pkg::*;
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sfr_res_if;
  import sfr_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [ByteW-1:0]     function_code;
  logic [ByteIdxW-1:0]  byte_index;
  logic [ByteW-1:0]     data_byte;
  logic [LenFieldW-1:0] payload_length;
  logic                 has_data;
  logic                 last;
  modport source (output valid, output function_code, output byte_index, output data_byte,
                  output payload_length, output has_data, output last, input ready);
  modport sink   (input valid, input function_code, input byte_index, input data_byte,
                  input payload_length, input has_data, input last, output ready);
endinterface

interface sfr_cfg_if;
  import sfr_pkg::*;
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [ByteW-1:0]   data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/sfr_ctrl.sv -----
// Frame parsing and result sequencing state machine.
`default_nettype none

module sfr_ctrl (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              rx_valid_i,
  output logic             rx_ready_o,
  input  sfr_pkg::status_t status_i,
  output sfr_pkg::cmd_t    cmd_o
);
  import sfr_pkg::*;

  typedef enum logic [2:0] {
    S_HEAD1,
    S_HEAD2,
    S_LENGTH,
    S_FUNCTION,
    S_COLLECT,
    S_EMIT_RD,
    S_EMIT_WR
  } state_e;

  state_e state_q, state_d;
  logic   rx_fire;

  assign rx_ready_o = (state_q != S_EMIT_RD) && (state_q != S_EMIT_WR);
  assign rx_fire    = rx_valid_i && rx_ready_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_HEAD1: begin
        if (rx_fire && status_i.rx_eq_h1) begin
          cmd_o.sum_load = 1'b1;
          state_d        = S_HEAD2;
        end
      end
      S_HEAD2: begin
        if (rx_fire) begin
          if (status_i.rx_eq_h2) begin
            cmd_o.sum_add = 1'b1;
            state_d       = S_LENGTH;
          end else begin
            state_d = S_HEAD1;
          end
        end
      end
      S_LENGTH: begin
        if (rx_fire) begin
          cmd_o.len_load = 1'b1;
          cmd_o.sum_add  = 1'b1;
          state_d        = S_FUNCTION;
        end
      end
      S_FUNCTION: begin
        if (rx_fire) begin
          cmd_o.func_load = 1'b1;
          cmd_o.sum_add   = 1'b1;
          cmd_o.fill_clr  = 1'b1;
          state_d         = S_COLLECT;
        end
      end
      S_COLLECT: begin
        if (rx_fire) begin
          priority if (status_i.len_bad) begin
            state_d = S_HEAD1;
          end else if (!status_i.fill_done) begin
            cmd_o.store_wr = 1'b1;
            cmd_o.sum_add  = 1'b1;
          end else begin
            cmd_o.fill_clr = 1'b1;
            if (status_i.sum_match) begin
              cmd_o.emit_start = 1'b1;
              state_d          = S_EMIT_RD;
            end else begin
              state_d = S_HEAD1;
            end
          end
        end
      end
      S_EMIT_RD: begin
        cmd_o.rd_en = 1'b1;
        state_d     = S_EMIT_WR;
      end
      S_EMIT_WR: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = status_i.emit_last ? S_HEAD1 : S_EMIT_RD;
        end
      end
      default: state_d = S_HEAD1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_HEAD1;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/sfr_dpath.sv -----
// Header registers, checksum, payload store and result register.
`default_nettype none

module sfr_dpath (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire [sfr_pkg::ByteW-1:0] rx_byte_i,
  input  sfr_pkg::cmd_t            cmd_i,
  output sfr_pkg::status_t         status_o,
  sfr_cfg_if.sink                  cfg_i,
  sfr_res_if.source                res_o
);
  import sfr_pkg::*;

  logic [ByteW-1:0] hdr1_q, hdr2_q;
  logic [ByteW-1:0] sum_q, sum_d;
  logic [ByteW-1:0] len_q, func_q;
  logic [CntW-1:0]  fill_q, k_q;
  logic [CntW-1:0]  plen;
  logic [ByteW-1:0] mem_q [BufferDepth];
  logic [ByteW-1:0] rd_data_q;
  logic             out_valid_q;
  logic             emit_last;

  assign plen      = CntW'(len_q - ByteW'(FrameOverhead + 1));
  assign emit_last = ({1'b0, k_q} + (CntW + 1)'(1)) >= {1'b0, plen};

  assign status_o.rx_eq_h1  = (rx_byte_i == hdr1_q);
  assign status_o.rx_eq_h2  = (rx_byte_i == hdr2_q);
  assign status_o.len_bad   = (len_q < ByteW'(FrameOverhead + 1))
                              || ({1'b0, len_q} > (ByteW + 1)'(MaxLength));
  assign status_o.fill_done = (fill_q == plen);
  assign status_o.sum_match = (sum_q == rx_byte_i);
  assign status_o.emit_last = emit_last;
  assign status_o.out_free  = !out_valid_q || res_o.ready;

  assign cfg_i.ready = 1'b1;
  assign res_o.valid = out_valid_q;

  always_comb begin
    sum_d = sum_q;
    priority if (cmd_i.sum_load) begin
      sum_d = rx_byte_i;
    end else if (cmd_i.sum_add) begin
      sum_d = sum_q + rx_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr1_q      <= HeaderFirstReset;
      hdr2_q      <= HeaderSecondReset;
      sum_q       <= '0;
      len_q       <= '0;
      func_q      <= '0;
      fill_q      <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_i.valid) begin
        unique case (cfg_i.index)
          CfgHeaderFirst:  hdr1_q <= cfg_i.data;
          CfgHeaderSecond: hdr2_q <= cfg_i.data;
        endcase
      end
      sum_q <= sum_d;
      if (cmd_i.len_load) begin
        len_q <= rx_byte_i;
      end
      if (cmd_i.func_load) begin
        func_q <= rx_byte_i;
      end
      if (cmd_i.fill_clr) begin
        fill_q <= '0;
      end else if (cmd_i.store_wr) begin
        fill_q <= fill_q + CntW'(1);
      end
      if (cmd_i.emit_start) begin
        k_q <= '0;
      end else if (cmd_i.out_load) begin
        k_q <= k_q + CntW'(1);
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.store_wr) begin
      mem_q[fill_q] <= rx_byte_i;
    end
    if (cmd_i.rd_en) begin
      rd_data_q <= mem_q[k_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      res_o.function_code  <= func_q;
      res_o.byte_index     <= ByteIdxW'(k_q);
      res_o.data_byte      <= (plen == '0) ? '0 : rd_data_q;
      res_o.payload_length <= LenFieldW'(plen);
      res_o.has_data       <= (plen != '0);
      res_o.last           <= emit_last;
    end
  end

  a_load_only_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> status_o.out_free)
    else $error("result register loaded while still occupied");

  a_store_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.store_wr |-> (fill_q < plen))
    else $error("payload write beyond frame data length");

  a_load_shows_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |=> out_valid_q)
    else $error("loaded result not presented");

endmodule

`default_nettype wire

// ----- rtl/sensor_frame_receiver.sv -----
// Top level of the sensor frame receiver: controller plus datapath.
// Takes one byte per cycle while hunting for and collecting a frame.
// After a good checksum byte each result takes a store read (S_EMIT_RD) and
// then a result load (S_EMIT_WR, which waits while the output is stalled);
// there is one result per payload byte, or one for an empty payload, and input is held off until the last is loaded.
// Reset is asynchronous, active low: hunt restarts, headers return to 170/85.
`default_nettype none

module sensor_frame_receiver (
  input  wire       clk_i,
  input  wire       rst_ni,
  sfr_rx_if.sink    rx_i,
  sfr_cfg_if.sink   cfg_i,
  sfr_res_if.source res_o
);
  import sfr_pkg::*;

  cmd_t    cmd;
  status_t status;

  sfr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rx_valid_i (rx_i.valid),
    .rx_ready_o (rx_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  sfr_dpath u_dpath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rx_byte_i (rx_i.rx_byte),
    .cmd_i     (cmd),
    .status_o  (status),
    .cfg_i     (cfg_i),
    .res_o     (res_o)
  );

endmodule

`default_nettype wire
